FILE: src/lld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lld_pkg;
   localparam int MaxPools = 16;
   localparam int SlotBits = $clog2(MaxPools);

   localparam logic [1:0] CMD_REPORT = 2'd0;
   localparam logic [1:0] CMD_CLOSE = 2'd1;
   localparam logic [1:0] CMD_ORDER = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam logic [1:0] KIND_EXISTING = 2'd0;
   localparam logic [1:0] KIND_NEW = 2'd1;
   localparam logic [1:0] KIND_CLOSE_ACK = 2'd2;
   localparam logic [1:0] KIND_FULL = 2'd3;

   localparam logic [9:0] QueueMax = 10'd1023;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic last;
   } stat_type;
endpackage
`default_nettype wire

FILE: src/least_loaded_dispatcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Least-loaded dispatcher for a table of worker pools.
// A command is taken when start is high and busy is low. Command 0 updates
// the reported counts of a pool, command 1 closes a pool, command 2 places
// an order on the best-ranked pool with spare capacity, or on a new pool
// in a free slot, or reports the table full. Every command scans all
// table slots, one slot per cycle, then passes through a done state that
// produces the result; busy stays high from acceptance to the end of the
// done state, and the next command can be taken once busy is low again.
// Orders and successful closes produce one result beat with rsp_valid high
// for one cycle, the first cycle in which busy is low again. Reports,
// command 3 and closes of unknown pools produce none. The receiver
// cannot stall the result.
// The csr channel writes the worker count per pool; it is always ready and
// is to be written only while busy is low.
// Synchronous reset empties the table, zeroes the next pool id and sets the
// worker count to 4.
module least_loaded_dispatcher (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [1:0] req_cmd,
   input  wire logic [15:0] req_kitchen_id,
   input  wire logic [7:0] req_idle_cooks,
   input  wire logic [9:0] req_queued_pizzas,
   input  wire logic [31:0] req_completion_time,
   input  wire logic [31:0] req_order_tag,
   input  wire logic req_first_of_batch,
   output logic rsp_valid,
   output logic [1:0] rsp_result_kind,
   output logic [15:0] rsp_target_id,
   output logic [31:0] rsp_order_word,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [7:0] csr_data
);
   import lld_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   assign csr_ready = 1'b1;

   lld_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .ctrl(ctrl), .stat(stat)
   );

   lld_dpath u_dpath (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .csr_valid(csr_valid), .csr_data(csr_data),
      .req_cmd(req_cmd), .req_kitchen_id(req_kitchen_id),
      .req_idle_cooks(req_idle_cooks), .req_queued_pizzas(req_queued_pizzas),
      .req_completion_time(req_completion_time), .req_order_tag(req_order_tag),
      .req_first_of_batch(req_first_of_batch),
      .rsp_valid(rsp_valid), .rsp_result_kind(rsp_result_kind),
      .rsp_target_id(rsp_target_id), .rsp_order_word(rsp_order_word)
   );
endmodule
`default_nettype wire

FILE: src/lld_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lld_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   output lld_pkg::ctrl_type ctrl,
   input  lld_pkg::stat_type stat
);
   import lld_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_SCAN;
         ST_SCAN: if (stat.last) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign ctrl.load = (state_ff == ST_IDLE) && start;
   assign ctrl.step = (state_ff == ST_SCAN);
   assign ctrl.finish = (state_ff == ST_DONE);
endmodule
`default_nettype wire

FILE: src/lld_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module lld_dpath (
   input  wire logic clock,
   input  wire logic reset,
   input  lld_pkg::ctrl_type ctrl,
   output lld_pkg::stat_type stat,
   input  wire logic csr_valid,
   input  wire logic [7:0] csr_data,
   input  wire logic [1:0] req_cmd,
   input  wire logic [15:0] req_kitchen_id,
   input  wire logic [7:0] req_idle_cooks,
   input  wire logic [9:0] req_queued_pizzas,
   input  wire logic [31:0] req_completion_time,
   input  wire logic [31:0] req_order_tag,
   input  wire logic req_first_of_batch,
   output logic rsp_valid,
   output logic [1:0] rsp_result_kind,
   output logic [15:0] rsp_target_id,
   output logic [31:0] rsp_order_word
);
   import lld_pkg::*;

   logic [7:0] cooks_ff;
   logic [MaxPools-1:0] valid_ff;
   logic [15:0] id_ff [MaxPools];
   logic [7:0] ridle_ff [MaxPools];
   logic [9:0] rqueue_ff [MaxPools];
   logic [31:0] rtime_ff [MaxPools];
   logic [7:0] widle_ff [MaxPools];
   logic [9:0] wqueue_ff [MaxPools];
   logic [15:0] next_id_ff;

   logic [1:0] cmd_ff;
   logic [15:0] kid_ff;
   logic [7:0] idle_ff;
   logic [9:0] queue_ff;
   logic [31:0] time_ff;
   logic [31:0] tag_ff;
   logic first_ff;

   logic [SlotBits-1:0] slot_ff;
   logic found_ff, free_found_ff;
   logic [SlotBits-1:0] best_ff, free_ff;
   logic [7:0] best_idle_ff;
   logic [9:0] best_queue_ff;
   logic [31:0] best_time_ff;
   logic [15:0] best_id_ff;

   logic [7:0] cur_idle;
   logic [9:0] cur_queue;
   logic cur_valid, id_hit, fits, better;

   assign cur_valid = valid_ff[slot_ff];
   assign id_hit = cur_valid && (id_ff[slot_ff] == kid_ff);
   // The batch reload is folded into the scan: on the first order of a batch each slot sees its reported counts.
   assign cur_idle = first_ff ? ridle_ff[slot_ff] : widle_ff[slot_ff];
   assign cur_queue = first_ff ? rqueue_ff[slot_ff] : wqueue_ff[slot_ff];
   assign fits = {1'b0, cur_queue} < ({3'b0, cooks_ff} + {3'b0, cur_idle});

   always_comb begin
      priority if (!found_ff) better = 1'b1;
      else if (cur_idle != best_idle_ff) better = cur_idle > best_idle_ff;
      else if (cur_queue != best_queue_ff) better = cur_queue > best_queue_ff;
      else if (rtime_ff[slot_ff] != best_time_ff) better = rtime_ff[slot_ff] < best_time_ff;
      else better = id_ff[slot_ff] < best_id_ff;
   end

   assign stat.last = (slot_ff == SlotBits'(MaxPools - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cooks_ff <= 8'd4;
         valid_ff <= '0;
         next_id_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_valid) cooks_ff <= csr_data;
         if (ctrl.load) begin
            cmd_ff <= req_cmd;
            kid_ff <= req_kitchen_id;
            idle_ff <= req_idle_cooks;
            queue_ff <= req_queued_pizzas;
            time_ff <= req_completion_time;
            tag_ff <= req_order_tag;
            first_ff <= req_first_of_batch;
            slot_ff <= '0;
            found_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end
         if (ctrl.step) begin
            slot_ff <= slot_ff + 1'b1;
            unique case (cmd_ff)
               CMD_REPORT: if (id_hit && !found_ff) begin
                  found_ff <= 1'b1;
                  ridle_ff[slot_ff] <= idle_ff;
                  rqueue_ff[slot_ff] <= queue_ff;
                  rtime_ff[slot_ff] <= time_ff;
               end
               CMD_CLOSE: if (id_hit) begin
                  found_ff <= 1'b1;
                  valid_ff[slot_ff] <= 1'b0;
               end
               CMD_ORDER: begin
                  if (cur_valid && first_ff) begin
                     widle_ff[slot_ff] <= ridle_ff[slot_ff];
                     wqueue_ff[slot_ff] <= rqueue_ff[slot_ff];
                  end
                  if (!cur_valid && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_ff <= slot_ff;
                  end
                  if (cur_valid && fits && better) begin
                     found_ff <= 1'b1;
                     best_ff <= slot_ff;
                     best_idle_ff <= cur_idle;
                     best_queue_ff <= cur_queue;
                     best_time_ff <= rtime_ff[slot_ff];
                     best_id_ff <= id_ff[slot_ff];
                  end
               end
               default: ;
            endcase
         end
         if (ctrl.finish) begin
            unique case (cmd_ff)
               CMD_CLOSE: begin
                  rsp_valid <= found_ff;
                  rsp_result_kind <= KIND_CLOSE_ACK;
                  rsp_target_id <= kid_ff;
                  rsp_order_word <= '0;
               end
               CMD_ORDER: begin
                  rsp_valid <= 1'b1;
                  rsp_order_word <= tag_ff;
                  priority if (found_ff) begin
                     rsp_result_kind <= KIND_EXISTING;
                     rsp_target_id <= best_id_ff;
                     if (best_idle_ff != 8'd0)
                        widle_ff[best_ff] <= best_idle_ff - 8'd1;
                     else if (best_queue_ff != QueueMax)
                        wqueue_ff[best_ff] <= best_queue_ff + 10'd1;
                  end else if (free_found_ff) begin
                     rsp_result_kind <= KIND_NEW;
                     rsp_target_id <= next_id_ff;
                     next_id_ff <= next_id_ff + 16'd1;
                     valid_ff[free_ff] <= 1'b1;
                     id_ff[free_ff] <= next_id_ff;
                     ridle_ff[free_ff] <= cooks_ff;
                     rqueue_ff[free_ff] <= '0;
                     rtime_ff[free_ff] <= '0;
                     // With no workers at all the order lands on the queue instead.
                     widle_ff[free_ff] <= (cooks_ff != 8'd0) ? cooks_ff - 8'd1 : 8'd0;
                     wqueue_ff[free_ff] <= (cooks_ff != 8'd0) ? 10'd0 : 10'd1;
                  end else begin
                     rsp_result_kind <= KIND_FULL;
                     rsp_target_id <= '0;
                  end
               end
               default: rsp_valid <= 1'b0;
            endcase
         end else begin
            rsp_valid <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

FILE: tb/lld_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lld_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic busy,
   input  wire logic [1:0] req_cmd,
   input  wire logic [15:0] req_kitchen_id,
   input  wire logic [7:0] req_idle_cooks,
   input  wire logic [9:0] req_queued_pizzas,
   input  wire logic [31:0] req_completion_time,
   input  wire logic [31:0] req_order_tag,
   input  wire logic req_first_of_batch,
   input  wire logic rsp_valid,
   input  wire logic [1:0] rsp_result_kind,
   input  wire logic [15:0] rsp_target_id,
   input  wire logic [31:0] rsp_order_word,
   input  wire logic csr_valid,
   input  wire logic csr_ready,
   input  wire logic [7:0] csr_data,
   output int fail_count,
   output int pending_results
);
   import lld_pkg::*;

   typedef struct packed {
      logic [1:0] kind;
      logic [15:0] target;
      logic [31:0] word;
   } dispatch_type;

   dispatch_type expected_dispatch[$];

   logic [7:0] workers;
   logic pool_live[MaxPools];
   logic [15:0] pool_id[MaxPools];
   logic [7:0] rep_idle[MaxPools];
   logic [9:0] rep_queue[MaxPools];
   logic [31:0] rep_time[MaxPools];
   logic [7:0] wrk_idle[MaxPools];
   logic [9:0] wrk_queue[MaxPools];
   logic [15:0] next_id;

   function automatic bit outranks(int a, int b);
      if (wrk_idle[a] != wrk_idle[b]) return wrk_idle[a] > wrk_idle[b];
      if (wrk_queue[a] != wrk_queue[b]) return wrk_queue[a] > wrk_queue[b];
      if (rep_time[a] != rep_time[b]) return rep_time[a] < rep_time[b];
      if (pool_id[a] != pool_id[b]) return pool_id[a] < pool_id[b];
      return a < b;
   endfunction

   task automatic charge_pool(int s);
      if (wrk_idle[s] != 8'd0) wrk_idle[s] = wrk_idle[s] - 8'd1;
      else if (wrk_queue[s] != QueueMax) wrk_queue[s] = wrk_queue[s] + 10'd1;
   endtask

   task automatic expect_beat(dispatch_type d);
      expected_dispatch.insert(expected_dispatch.size(), d);
   endtask

   task automatic predict_dispatch();
      int best;
      int free_slot;
      bit found;
      dispatch_type d;
      best = -1;
      free_slot = -1;
      found = 0;
      d = '0;
      case (req_cmd)
         CMD_REPORT: begin
            for (int s = 0; s < MaxPools; s++) begin
               if (!found && pool_live[s] && pool_id[s] == req_kitchen_id) begin
                  rep_idle[s] = req_idle_cooks;
                  rep_queue[s] = req_queued_pizzas;
                  rep_time[s] = req_completion_time;
                  found = 1;
               end
            end
         end
         CMD_CLOSE: begin
            for (int s = 0; s < MaxPools; s++) begin
               if (pool_live[s] && pool_id[s] == req_kitchen_id) begin
                  pool_live[s] = 0;
                  found = 1;
               end
            end
            if (found) begin
               d.kind = KIND_CLOSE_ACK;
               d.target = req_kitchen_id;
               expect_beat(d);
            end
         end
         CMD_ORDER: begin
            for (int s = 0; s < MaxPools; s++) begin
               if (req_first_of_batch && pool_live[s]) begin
                  wrk_idle[s] = rep_idle[s];
                  wrk_queue[s] = rep_queue[s];
               end
            end
            for (int s = 0; s < MaxPools; s++) begin
               if (!pool_live[s]) begin
                  if (free_slot < 0) free_slot = s;
               end else if (int'(wrk_queue[s]) < int'(workers) + int'(wrk_idle[s])) begin
                  if (best < 0 || outranks(s, best)) best = s;
               end
            end
            d.word = req_order_tag;
            if (best >= 0) begin
               charge_pool(best);
               d.kind = KIND_EXISTING;
               d.target = pool_id[best];
            end else if (free_slot < 0) begin
               d.kind = KIND_FULL;
            end else begin
               pool_live[free_slot] = 1;
               pool_id[free_slot] = next_id;
               rep_idle[free_slot] = workers;
               rep_queue[free_slot] = '0;
               rep_time[free_slot] = '0;
               wrk_idle[free_slot] = workers;
               wrk_queue[free_slot] = '0;
               next_id = next_id + 16'd1;
               charge_pool(free_slot);
               d.kind = KIND_NEW;
               d.target = pool_id[free_slot];
            end
            expect_beat(d);
         end
         default: ;
      endcase
   endtask

   task automatic note_mismatch(string what, dispatch_type want);
      if (fail_count < 10)
         $display("%0t %s: expected kind %0d id %0d word %h, got kind %0d id %0d word %h",
                  $realtime, what, want.kind, want.target, want.word,
                  rsp_result_kind, rsp_target_id, rsp_order_word);
      fail_count = fail_count + 1;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      dispatch_type want;
      if (reset) begin
         workers = 8'd4;
         next_id = '0;
         for (int s = 0; s < MaxPools; s++) pool_live[s] = 0;
         expected_dispatch.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_dispatch.size() == 0) begin
               want = '0;
               note_mismatch("unexpected result", want);
            end else begin
               want = expected_dispatch.pop_front();
               if (rsp_result_kind != want.kind || rsp_target_id != want.target ||
                   rsp_order_word != want.word)
                  note_mismatch("result mismatch", want);
            end
         end
         if (csr_valid && csr_ready) workers = csr_data;
         if (start && !busy) predict_dispatch();
      end
      pending_results = expected_dispatch.size();
   end
endmodule
`default_nettype wire

FILE: tb/least_loaded_dispatcher_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module least_loaded_dispatcher_tb;
   import lld_pkg::*;

   localparam int StallLimit = 4000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_cmd = '0;
   logic [15:0] req_kitchen_id = '0;
   logic [7:0] req_idle_cooks = '0;
   logic [9:0] req_queued_pizzas = '0;
   logic [31:0] req_completion_time = '0;
   logic [31:0] req_order_tag = '0;
   logic req_first_of_batch = 0;
   logic rsp_valid;
   logic [1:0] rsp_result_kind;
   logic [15:0] rsp_target_id;
   logic [31:0] rsp_order_word;
   logic csr_valid = 0;
   logic csr_ready;
   logic [7:0] csr_data = '0;
   int fail_count;
   int pending_results;
   int quiet_cycles = 0;
   logic [15:0] known_ids[16];
   int known_ptr = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   least_loaded_dispatcher dut (.*);

   lld_checker checker_i (.*);

   // The watchdog restarts on every beat of any channel.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Freshly created pool ids make good targets for reports and closes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_result_kind == KIND_NEW) begin
         known_ids[known_ptr] <= rsp_target_id;
         known_ptr <= (known_ptr + 1) % 16;
      end
   end

   task automatic send(logic [1:0] cmd, logic [15:0] id, logic [7:0] idle,
                       logic [9:0] queue, logic [31:0] ctime, logic [31:0] tag,
                       logic first);
      @(negedge clock);
      start <= 1;
      req_cmd <= cmd;
      req_kitchen_id <= id;
      req_idle_cooks <= idle;
      req_queued_pizzas <= queue;
      req_completion_time <= ctime;
      req_order_tag <= tag;
      req_first_of_batch <= first;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(int n);
      @(negedge clock);
      start <= 0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic write_workers(logic [7:0] value);
      idle_for(1);
      while (pending_results != 0) @(negedge clock);
      repeat (24) @(negedge clock);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [15:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return known_ids[$urandom_range(0, 15)];
      if (r < 85) return 16'($urandom_range(0, 40));
      return 16'($urandom);
   endfunction

   task automatic random_item();
      int r;
      logic [1:0] cmd;
      logic [7:0] idle;
      logic [9:0] queue;
      r = $urandom_range(0, 99);
      if (r < 48) cmd = CMD_ORDER;
      else if (r < 78) cmd = CMD_REPORT;
      else if (r < 95) cmd = CMD_CLOSE;
      else cmd = CMD_NONE;
      if ($urandom_range(0, 1)) begin
         idle = 8'($urandom);
         queue = 10'($urandom);
      end else begin
         idle = 8'($urandom_range(0, 6));
         queue = 10'($urandom_range(0, 8));
      end
      send(cmd, pick_id(), idle, queue, $urandom, $urandom, $urandom_range(0, 99) < 20);
   endtask

   initial begin
      logic [7:0] settings[5];
      for (int k = 0; k < 16; k++) known_ids[k] = 16'(k);
      settings = '{8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 254)), 8'd4};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part at the reset worker count of four.
      send(CMD_ORDER, 16'd0, 8'd0, 10'd0, 32'd0, 32'hFFFF_FFFF, 1);
      send(CMD_ORDER, 16'd0, 8'd0, 10'd0, 32'd0, 32'd0, 0);
      send(CMD_REPORT, 16'd0, 8'hFF, 10'h3FF, 32'hFFFF_FFFF, 32'd0, 0);
      send(CMD_ORDER, 16'd0, 8'd0, 10'd0, 32'd0, 32'h1234_5678, 1);
      send(CMD_REPORT, 16'd0, 8'd0, 10'h3FF, 32'd0, 32'd0, 0);
      send(CMD_ORDER, 16'd0, 8'd0, 10'd0, 32'd0, 32'hA5A5_5A5A, 1);
      send(CMD_ORDER, 16'd0, 8'd0, 10'd0, 32'd0, 32'h5A5A_A5A5, 0);
      send(CMD_REPORT, 16'd1, 8'd4, 10'd0, 32'd7, 32'd0, 0);
      send(CMD_REPORT, 16'hFFFF, 8'd1, 10'd1, 32'd1, 32'd0, 0);
      send(CMD_ORDER, 16'd0, 8'd0, 10'd0, 32'd0, 32'd3, 1);
      send(CMD_CLOSE, 16'd0, 8'd0, 10'd0, 32'd0, 32'd0, 0);
      send(CMD_CLOSE, 16'd0, 8'd0, 10'd0, 32'd0, 32'd0, 0);
      send(CMD_CLOSE, 16'hFFFF, 8'd0, 10'd0, 32'd0, 32'd0, 0);
      send(CMD_NONE, 16'hFFFF, 8'hFF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send(CMD_ORDER, 16'd0, 8'd0, 10'd0, 32'd0, 32'd9, 0);

      // Each phase holds one worker count; a count of one fills the table fast.
      for (int phase = 0; phase < 5; phase++) begin
         write_workers(settings[phase]);
         for (int n = 0; n < 250; n++) begin
            if (!(phase == 1 && n > 50 && n < 200) && $urandom_range(0, 99) < 37)
               idle_for($urandom_range(1, 6));
            random_item();
         end
      end

      idle_for(1);
      while (pending_results != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (fail_count == 0 && pending_results == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
